// ===== rtl/core/bhl_pkg.sv =====
// Shared widths, constants and helpers of the Bezier height lookup.
// Used by the top level and by the testbench; no dependencies.
package bhl_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int T_W        = FRAC_BITS + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  localparam int A_W   = COORD_BITS + 2;
  localparam int H_W   = COORD_BITS + 1;
  localparam int E_W   = COORD_BITS + 1;
  localparam int D_W   = 2 * E_W;
  localparam int N_W   = COORD_BITS + 2 + FRAC_BITS;
  localparam int DEN_W = COORD_BITS + 1;

  localparam int MUL_A_W = (COORD_BITS + 1 > 2 * FRAC_BITS + 1) ? COORD_BITS + 1
                                                                : 2 * FRAC_BITS + 1;
  localparam int MUL_B_W = (COORD_BITS > T_W) ? COORD_BITS : T_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = PROD_W + 1;

  localparam int IN_FIELDS_W  = 4 + 7 * COORD_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COORD_BITS + 4;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // A quotient magnitude with its sign is a usable parameter when it lies in [0, 1].
  function automatic logic t_ok(input logic [N_W-1:0] q, input logic neg);
    logic zero;
    begin
      zero = (q == '0);
      t_ok = zero || (!neg && (q <= N_W'(T_ONE)));
    end
  endfunction

endpackage

// ===== rtl/core/piecewise_bezier_height_lookup.sv =====
// Piecewise quadratic Bezier height lookup, top level.
// A load writes one table slot. A query scans segments one at a time on shared
// bit-serial units: a vertical segment is skipped, a straight one takes a divide, one with a
// negative discriminant ends after the two products, a full quadratic solve adds a root and up
// to two divides, then the height of the hit segment is formed and registered. One item is in flight at a time.
// Reset (rst_n, synchronous) clears the count register and control; the table is not cleared.
module piecewise_bezier_height_lookup
  import bhl_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // seg_index, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, query_x, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // height, hit_segment, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic                   out_tuser,
  input  logic                   cfg_wr_en,
  input  logic [4:0]             cfg_wr_data
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int CB = COORD_BITS;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_RD    = 12'b0000_0000_0010,
    ST_SETUP = 12'b0000_0000_0100,
    ST_MHH   = 12'b0000_0000_1000,
    ST_MAC   = 12'b0000_0001_0000,
    ST_SQRT  = 12'b0000_0010_0000,
    ST_DIV1  = 12'b0000_0100_0000,
    ST_DIV2  = 12'b0000_1000_0000,
    ST_LDIV  = 12'b0001_0000_0000,
    ST_HMUL  = 12'b0010_0000_0000,
    ST_NEXT  = 12'b0100_0000_0000,
    ST_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Input fields
  logic [3:0]           in_seg_index;
  logic signed [CB-1:0] in_start_x, in_start_y, in_ctrl_x, in_ctrl_y, in_end_x, in_end_y;
  logic signed [CB-1:0] in_query_x;

  assign in_seg_index = in_tdata[3:0];
  assign in_start_x   = in_tdata[4 +: CB];
  assign in_start_y   = in_tdata[4 + CB +: CB];
  assign in_ctrl_x    = in_tdata[4 + 2*CB +: CB];
  assign in_ctrl_y    = in_tdata[4 + 3*CB +: CB];
  assign in_end_x     = in_tdata[4 + 4*CB +: CB];
  assign in_end_y     = in_tdata[4 + 5*CB +: CB];
  assign in_query_x   = in_tdata[4 + 6*CB +: CB];

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration
  logic [4:0] seg_count_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= '0;
    end else if (cfg_wr_en) begin
      seg_count_r <= cfg_wr_data;
    end
  end

  logic [CW-1:0] lim_now;
  assign lim_now = (32'(seg_count_r) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS) : CW'(seg_count_r);

  // Segment table
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [6*CB-1:0] ram_rdata;
  logic            ram_we;

  assign ram_we = in_acc && (in_tuser == OP_LOAD) && (32'(in_seg_index) < MAX_SEGMENTS);

  bhl_ram #(
    .WIDTH (6 * CB),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_seg_index)),
    .wdata ({in_end_y, in_end_x, in_ctrl_y, in_ctrl_x, in_start_y, in_start_x}),
    .re    (state_r == ST_RD),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  logic signed [CB-1:0] rd_sx, rd_cx, rd_ex;
  logic [CB-1:0]        rd_sy, rd_cy, rd_ey;
  assign rd_sx = ram_rdata[0 +: CB];
  assign rd_sy = ram_rdata[CB +: CB];
  assign rd_cx = ram_rdata[2*CB +: CB];
  assign rd_cy = ram_rdata[3*CB +: CB];
  assign rd_ex = ram_rdata[4*CB +: CB];
  assign rd_ey = ram_rdata[5*CB +: CB];

  // Working registers
  logic signed [CB-1:0] x_r, x_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;
  logic signed [A_W-1:0] a_r, a_nxt;
  logic signed [H_W-1:0] h_r, h_nxt;
  logic signed [H_W-1:0] c_r, c_nxt;
  logic [CB-1:0]        sy_r, sy_nxt, cy_r, cy_nxt, ey_r, ey_nxt;
  logic [E_W-1:0]       e_r, e_nxt;
  logic [2*CB-1:0]      hh_r, hh_nxt;
  logic [D_W-1:0]       d_r, d_nxt;
  logic [N_W-1:0]       dnum_r, dnum_nxt;
  logic [DEN_W-1:0]     dden_r, dden_nxt;
  logic                 neg_r, neg_nxt;
  logic [T_W-1:0]       t_r, t_nxt;
  logic [MUL_A_W-1:0]   w_r, w_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [2:0]           hstep_r, hstep_nxt;
  logic                 found_r, found_nxt;
  logic                 mgo_r, mgo_nxt, sgo_r, sgo_nxt, dgo_r, dgo_nxt;

  // Arithmetic units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done, sqrt_done, div_done;
  logic [PROD_W-1:0]  prod;
  logic [E_W-1:0]     root;
  logic [N_W-1:0]     quot;

  bhl_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk (clk), .rst_n (rst_n), .start (mgo_r), .op_a (mul_a), .op_b (mul_b),
    .done (mul_done), .prod (prod)
  );

  bhl_sqrt #(.R_W(E_W)) u_sqrt (
    .clk (clk), .rst_n (rst_n), .start (sgo_r), .radicand (d_r),
    .done (sqrt_done), .root (root)
  );

  bhl_div #(.NUM_W(N_W), .DEN_W(DEN_W)) u_div (
    .clk (clk), .rst_n (rst_n), .start (dgo_r), .num (dnum_r), .den (dden_r),
    .done (div_done), .quot (quot)
  );

  // Magnitudes of the stored coefficients
  logic [CB-1:0]  habs, cabs;
  logic [CB:0]    aabs;
  logic [H_W-1:0] hneg, cneg;
  logic [A_W-1:0] aneg;
  assign hneg = -h_r;
  assign cneg = -c_r;
  assign aneg = -a_r;
  assign habs = h_r[H_W-1] ? hneg[CB-1:0] : h_r[CB-1:0];
  assign cabs = c_r[H_W-1] ? cneg[CB-1:0] : c_r[CB-1:0];
  assign aabs = a_r[A_W-1] ? aneg[CB:0] : a_r[CB:0];

  logic [T_W-1:0] u_val;
  assign u_val = T_ONE - t_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MHH: begin
        mul_a = MUL_A_W'(habs);
        mul_b = MUL_B_W'(habs);
      end
      ST_MAC: begin
        mul_a = MUL_A_W'(aabs);
        mul_b = MUL_B_W'(cabs);
      end
      ST_HMUL: begin
        case (hstep_r)
          3'd0: begin mul_a = MUL_A_W'(u_val); mul_b = MUL_B_W'(u_val); end
          3'd1: begin mul_a = w_r;             mul_b = MUL_B_W'(sy_r);  end
          3'd2: begin mul_a = MUL_A_W'(u_val); mul_b = MUL_B_W'(t_r);   end
          3'd3: begin mul_a = w_r << 1;        mul_b = MUL_B_W'(cy_r);  end
          3'd4: begin mul_a = MUL_A_W'(t_r);   mul_b = MUL_B_W'(t_r);   end
          3'd5: begin mul_a = w_r;             mul_b = MUL_B_W'(ey_r);  end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Segment setup values
  logic signed [A_W-1:0] a_new;
  logic signed [H_W-1:0] h_new, c_new;
  assign a_new = A_W'(rd_sx) - (A_W'(rd_cx) <<< 1) + A_W'(rd_ex);
  assign h_new = H_W'(rd_cx) - H_W'(rd_sx);
  assign c_new = H_W'(rd_sx) - H_W'(x_r);

  logic [H_W-1:0] h_new_neg, c_new_neg;
  assign h_new_neg = -h_new;
  assign c_new_neg = -c_new;

  // Discriminant from the two products
  logic [2*CB:0] ac;
  logic [D_W-1:0] d_sum, d_diff;
  logic           ac_big;
  assign ac     = prod[2*CB:0];
  assign d_sum  = D_W'(hh_r) + D_W'(ac);
  assign d_diff = D_W'(hh_r) - D_W'(ac);
  assign ac_big = (D_W'(ac) > D_W'(hh_r));

  // Numerators of the two quadratic roots
  logic signed [CB+2:0] n1, n2;
  logic [CB+2:0]        n1_neg, n2_neg;
  logic [CB+1:0]        n1_abs, n2_abs;
  assign n1     = $signed({2'b00, root}) - (CB+3)'(h_r);
  assign n2     = -(CB+3)'(h_r) - $signed({2'b00, e_r});
  assign n1_neg = -n1;
  assign n2_neg = -n2;
  assign n1_abs = n1[CB+2] ? n1_neg[CB+1:0] : n1[CB+1:0];
  assign n2_abs = n2[CB+2] ? n2_neg[CB+1:0] : n2[CB+1:0];

  logic q_ok;
  assign q_ok = t_ok(quot, neg_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    lim_nxt   = lim_r;
    a_nxt     = a_r;
    h_nxt     = h_r;
    c_nxt     = c_r;
    sy_nxt    = sy_r;
    cy_nxt    = cy_r;
    ey_nxt    = ey_r;
    e_nxt     = e_r;
    hh_nxt    = hh_r;
    d_nxt     = d_r;
    dnum_nxt  = dnum_r;
    dden_nxt  = dden_r;
    neg_nxt   = neg_r;
    t_nxt     = t_r;
    w_nxt     = w_r;
    sum_nxt   = sum_r;
    hstep_nxt = hstep_r;
    found_nxt = found_r;
    mgo_nxt   = 1'b0;
    sgo_nxt   = 1'b0;
    dgo_nxt   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_QUERY)) begin
          x_nxt     = in_query_x;
          lim_nxt   = lim_now;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (lim_now == '0) ? ST_FIN : ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        a_nxt  = a_new;
        h_nxt  = h_new;
        c_nxt  = c_new;
        // Y values are kept offset to unsigned for the weighted sum.
        sy_nxt = {~rd_sy[CB-1], rd_sy[CB-2:0]};
        cy_nxt = {~rd_cy[CB-1], rd_cy[CB-2:0]};
        ey_nxt = {~rd_ey[CB-1], rd_ey[CB-2:0]};
        if (a_new == '0) begin
          if (h_new == '0) begin
            state_nxt = ST_NEXT;
          end else begin
            // Straight segment: t = -c / (2h).
            dnum_nxt  = N_W'({(c_new[H_W-1] ? c_new_neg[CB-1:0] : c_new[CB-1:0]),
                              {FRAC_BITS{1'b0}}});
            dden_nxt  = DEN_W'({(h_new[H_W-1] ? h_new_neg[CB-1:0] : h_new[CB-1:0]), 1'b0});
            neg_nxt   = (c_new > 0) ^ h_new[H_W-1];
            dgo_nxt   = 1'b1;
            state_nxt = ST_LDIV;
          end
        end else begin
          mgo_nxt   = 1'b1;
          state_nxt = ST_MHH;
        end
      end
      ST_MHH: begin
        if (mul_done) begin
          hh_nxt    = prod[2*CB-1:0];
          mgo_nxt   = 1'b1;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mul_done) begin
          if (a_r[A_W-1] != c_r[H_W-1]) begin
            d_nxt     = d_sum;
            sgo_nxt   = 1'b1;
            state_nxt = ST_SQRT;
          end else if (ac_big) begin
            state_nxt = ST_NEXT;
          end else begin
            d_nxt     = d_diff;
            sgo_nxt   = 1'b1;
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          e_nxt     = root;
          dnum_nxt  = N_W'({n1_abs, {FRAC_BITS{1'b0}}});
          dden_nxt  = DEN_W'(aabs);
          neg_nxt   = n1[CB+2] ^ a_r[A_W-1];
          dgo_nxt   = 1'b1;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          if (q_ok) begin
            t_nxt     = quot[T_W-1:0];
            sum_nxt   = '0;
            hstep_nxt = '0;
            mgo_nxt   = 1'b1;
            state_nxt = ST_HMUL;
          end else begin
            dnum_nxt  = N_W'({n2_abs, {FRAC_BITS{1'b0}}});
            neg_nxt   = n2[CB+2] ^ a_r[A_W-1];
            dgo_nxt   = 1'b1;
            state_nxt = ST_DIV2;
          end
        end
      end
      ST_DIV2, ST_LDIV: begin
        if (div_done) begin
          if (q_ok) begin
            t_nxt     = quot[T_W-1:0];
            sum_nxt   = '0;
            hstep_nxt = '0;
            mgo_nxt   = 1'b1;
            state_nxt = ST_HMUL;
          end else begin
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_HMUL: begin
        // Even steps form a weight, odd steps scale it by a Y value and accumulate.
        if (mul_done) begin
          if (hstep_r[0]) begin
            sum_nxt = sum_r + SUM_W'(prod);
          end else begin
            w_nxt = prod[MUL_A_W-1:0];
          end
          if (hstep_r == 3'd5) begin
            found_nxt = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            hstep_nxt = hstep_r + 3'd1;
            mgo_nxt   = 1'b1;
          end
        end
      end
      ST_NEXT: begin
        if (CW'(cnt_r + CW'(1)) == lim_r) begin
          found_nxt = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        if (!out_tvalid || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mgo_r   <= 1'b0;
      sgo_r   <= 1'b0;
      dgo_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mgo_r   <= mgo_nxt;
      sgo_r   <= sgo_nxt;
      dgo_r   <= dgo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    lim_r   <= lim_nxt;
    a_r     <= a_nxt;
    h_r     <= h_nxt;
    c_r     <= c_nxt;
    sy_r    <= sy_nxt;
    cy_r    <= cy_nxt;
    ey_r    <= ey_nxt;
    e_r     <= e_nxt;
    hh_r    <= hh_nxt;
    d_r     <= d_nxt;
    dnum_r  <= dnum_nxt;
    dden_r  <= dden_nxt;
    neg_r   <= neg_nxt;
    t_r     <= t_nxt;
    w_r     <= w_nxt;
    sum_r   <= sum_nxt;
    hstep_r <= hstep_nxt;
    found_r <= found_nxt;
  end

  // Round to nearest, saturate, then remove the offset.
  logic [SUM_W-1:0]     rounded;
  logic [SUM_W-33:0]    q_full;
  logic [CB-1:0]        q_sat;
  assign rounded = sum_r + (SUM_W'(1) << 31);
  assign q_full  = rounded[SUM_W-1:32];
  assign q_sat   = (q_full > (SUM_W-32)'({CB{1'b1}})) ? {CB{1'b1}} : q_full[CB-1:0];

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CB-1:0]        height_r;
  logic [3:0]           hit_r;
  logic                 found_out_r;
  logic                 out_load;

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found_out_r <= found_r;
      height_r    <= found_r ? {~q_sat[CB-1], q_sat[CB-2:0]} : '0;
      hit_r       <= found_r ? 4'(cnt_r) : 4'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_out_r;
  assign out_tdata  = OUT_TDATA_W'({hit_r, height_r});

endmodule

// ===== rtl/core/bhl_ram.sv =====
// Generic single-port-write, registered-read RAM.
// Holds the segment table; no dependencies.
module bhl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bhl_mul.sv =====
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; used by the top level for all products.
module bhl_mul #(
  parameter int A_W = 33,
  parameter int B_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [A_W-1:0]   op_a,
  input  logic [B_W-1:0]   op_b,
  output logic             done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W);

  logic [A_W-1:0]   a_r;
  logic [A_W-1:0]   hi_r;
  logic [B_W-1:0]   lo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [A_W:0]     sum;

  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign done = done_r;
  assign prod = {hi_r, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= op_a;
      hi_r <= '0;
      lo_r <= op_b;
    end else if (busy_r) begin
      hi_r <= sum[A_W:1];
      lo_r <= {sum[0], lo_r[B_W-1:1]};
    end
  end

endmodule

// ===== rtl/core/bhl_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone; used by the top level for the discriminant.
module bhl_sqrt #(
  parameter int R_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2*R_W-1:0] radicand,
  output logic             done,
  output logic [R_W-1:0]   root
);

  localparam int CNT_W = $clog2(R_W);

  logic [2*R_W-1:0] d_r;
  logic [R_W+2:0]   rem_r;
  logic [R_W-1:0]   root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [R_W+2:0]   rem_t;
  logic [R_W+2:0]   trial;
  logic             fits;

  assign rem_t = {rem_r[R_W:0], d_r[2*R_W-1 -: 2]};
  assign trial = (R_W+3)'({root_r, 2'b01});
  assign fits  = (rem_t >= trial);
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(R_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      d_r    <= {d_r[2*R_W-3:0], 2'b00};
      rem_r  <= fits ? rem_t - trial : rem_t;
      root_r <= {root_r[R_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/bhl_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the top level for the curve parameter.
module bhl_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_t;
  logic             fits;

  assign rem_t = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
  assign fits  = (rem_t >= {1'b0, den_r});
  assign done  = done_r;
  assign quot  = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_t - {1'b0, den_r} : rem_t;
      num_r <= {num_r[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== sim/tb_piecewise_bezier_height_lookup.sv =====
// Self-checking testbench for the piecewise Bezier height lookup.
// It needs bhl_pkg and the top level; the expected heights come from its own integer solver or the directed table.
`timescale 1ns / 100ps

module tb_piecewise_bezier_height_lookup;
  import bhl_pkg::*;

  localparam int SLOTS       = 16;
  localparam int SETTLE      = 4000;
  localparam longint LIMIT   = 40000000;
  localparam longint ONE_T   = 65536;

  typedef enum int { ROW_LOAD, ROW_QUERY, ROW_COUNT } row_kind_t;

  typedef struct {
    logic [COORD_BITS-1:0] height;
    logic                  found;
    logic [3:0]            hit;
  } height_res_t;

  typedef struct {
    row_kind_t kind;
    int        idx;
    int        sx, sy, cx, cy, ex, ey;
    int        qx;
    bit        typed;
    int        eh;
    int        ef;
    int        ehit;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [4:0]             cfg_wr_data = '0;

  longint      tab_sx[SLOTS], tab_sy[SLOTS], tab_cx[SLOTS];
  longint      tab_cy[SLOTS], tab_ex[SLOTS], tab_ey[SLOTS];
  int          seg_cnt;
  height_res_t pending_heights[$];
  int          errors = 0;
  longint      cycles = 0;
  int          stall_left = 0;

  piecewise_bezier_height_lookup dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint isqrt(input longint d);
    longint r;
    longint cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand <= d) r = cand;
    end
    return r;
  endfunction

  function automatic bit t_in_range(input longint t);
    return t >= 0 && t <= ONE_T;
  endfunction

  // Curve parameter of slot i at position x; returns 1 when the slot covers x.
  function automatic bit solve_param(input int i, input longint x, output longint t);
    longint a, h, c, d, e, t1, t2;
    a = tab_sx[i] - 2 * tab_cx[i] + tab_ex[i];
    h = tab_cx[i] - tab_sx[i];
    c = tab_sx[i] - x;
    t = 0;
    if (a == 0) begin
      // A straight segment; a vertical one never covers anything.
      if (h == 0) return 1'b0;
      t = (-c * ONE_T) / (2 * h);
      return t_in_range(t);
    end
    d = h * h - a * c;
    if (d < 0) return 1'b0;
    e  = isqrt(d);
    t1 = ((e - h) * ONE_T) / a;
    t2 = ((-h - e) * ONE_T) / a;
    if (t_in_range(t1)) begin
      t = t1;
      return 1'b1;
    end
    if (t_in_range(t2)) begin
      t = t2;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic height_res_t predict_height(input longint x);
    height_res_t r;
    longint      t;
    logic [63:0] off, tu, uu, sy, cy, ey, sum, q;
    int          n;
    r   = '{default: '0};
    off = 64'd1 << (COORD_BITS - 1);
    n   = (seg_cnt > SLOTS) ? SLOTS : seg_cnt;
    for (int i = 0; i < n; i++) begin
      if (solve_param(i, x, t)) begin
        tu  = 64'(t);
        uu  = 64'(ONE_T) - tu;
        sy  = 64'(tab_sy[i]) + off;
        cy  = 64'(tab_cy[i]) + off;
        ey  = 64'(tab_ey[i]) + off;
        sum = uu * uu * sy + 2 * uu * tu * cy + tu * tu * ey;
        q   = (sum + (64'd1 << 31)) >> 32;
        if (q > 64'((1 << COORD_BITS) - 1)) q = 64'((1 << COORD_BITS) - 1);
        r.height = COORD_BITS'(q - off);
        r.found  = 1'b1;
        r.hit    = 4'(i);
        return r;
      end
    end
    return r;
  endfunction

  // One input transaction. The valid stays high on return so that a zero gap follows on.
  task automatic send_item(input logic op, input int idx, input int sx, input int sy,
                           input int cx, input int cy, input int ex, input int ey,
                           input int qx, input bit typed, input height_res_t typed_res);
    logic [IN_TDATA_W-1:0] v;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    v = '0;
    v[3:0]     = 4'(idx);
    v[27:4]    = 24'(sx);
    v[51:28]   = 24'(sy);
    v[75:52]   = 24'(cx);
    v[99:76]   = 24'(cy);
    v[123:100] = 24'(ex);
    v[147:124] = 24'(ey);
    v[171:148] = 24'(qx);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      tab_sx[idx] = longint'(signed'(24'(sx)));
      tab_sy[idx] = longint'(signed'(24'(sy)));
      tab_cx[idx] = longint'(signed'(24'(cx)));
      tab_cy[idx] = longint'(signed'(24'(cy)));
      tab_ex[idx] = longint'(signed'(24'(ex)));
      tab_ey[idx] = longint'(signed'(24'(ey)));
    end else if (typed) begin
      pending_heights.insert(pending_heights.size(), typed_res);
    end else begin
      pending_heights.insert(pending_heights.size(),
                             predict_height(longint'(signed'(24'(qx)))));
    end
  endtask

  // Stops sending, lets every result drain and the block settle.
  task automatic drain_block();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 5'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seg_cnt = v;
  endtask

  function automatic int rnd_coord();
    logic [23:0] r;
    r = 24'($urandom);
    return int'(signed'(r));
  endfunction

  task automatic load_random(input int idx);
    int sx, ex, cx, mode;
    height_res_t none;
    none = '{default: '0};
    mode = $urandom_range(0, 19);
    sx = int'($urandom_range(0, 8000000)) - 4000000;
    ex = sx + int'($urandom_range(0, 4000000)) - 2000000;
    cx = sx + int'($urandom_range(0, 4000000)) - 2000000;
    if (mode < 3) begin
      // Straight segment: the control point sits exactly half way.
      ex = sx + 2 * (int'($urandom_range(0, 1000000)) - 500000);
      cx = (sx + ex) / 2;
    end else if (mode == 3) begin
      ex = sx;
      cx = sx;
    end else if (mode < 9) begin
      sx = rnd_coord();
      cx = rnd_coord();
      ex = rnd_coord();
    end
    send_item(OP_LOAD, idx, sx, rnd_coord(), cx, rnd_coord(), ex, rnd_coord(), rnd_coord(),
              1'b0, none);
  endtask

  // Results are taken with random back-pressure and compared with the oldest expectation.
  always @(posedge clk) begin
    height_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_heights.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %h", out_tdata);
      end else begin
        want = pending_heights.pop_front();
        if (out_tdata[23:0] !== want.height || out_tuser !== want.found ||
            out_tdata[27:24] !== want.hit) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: height %h found %b hit %0d, expected %h %b %0d",
                     out_tdata[23:0], out_tuser, out_tdata[27:24],
                     want.height, want.found, want.hit);
        end
      end
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_tready <= (stall_left == 0);
  end

  initial begin
    dir_row_t    dir_tab[20];
    height_res_t tr;
    int          total, n, slot, lo, hi, phase_len;
    int          counts[12] = '{16, 1, 31, 2, 0, 3, 17, 4, 2, 8, 1, 3};

    seg_cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tab_sx[i] = 0; tab_sy[i] = 0; tab_cx[i] = 0;
      tab_cy[i] = 0; tab_ex[i] = 0; tab_ey[i] = 0;
    end
    dir_tab = '{
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{ROW_LOAD, 0, 0, 0, 65536, 65536, 131072, 0, 0, 0, 0, 0, 0},
      '{ROW_LOAD, 1, 1048576, 5, 1048576, -5, 1048576, 7, 0, 0, 0, 0, 0},
      '{ROW_LOAD, 2, -8388608, -8388608, 0, 8388607, 8388607, 8388607, 0, 0, 0, 0, 0},
      '{ROW_LOAD, 3, 0, 0, 0, 65536, 65536, 65536, 0, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 65536, 1, 0, 0, 0},
      '{ROW_COUNT, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 65536, 1, 32768, 1, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 131072, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0},
      '{ROW_COUNT, 0, 0, 0, 0, 0, 0, 0, 4, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 1048576, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, -8388608, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 8388607, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 32768, 0, 0, 0, 0},
      '{ROW_COUNT, 0, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, -4000000, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 40000, 0, 0, 0, 0},
      '{ROW_QUERY, 0, 0, 0, 0, 0, 0, 0, 8000000, 0, 0, 0, 0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      tr = '{height: COORD_BITS'(dir_tab[k].eh), found: dir_tab[k].ef[0],
             hit: 4'(dir_tab[k].ehit)};
      case (dir_tab[k].kind)
        ROW_COUNT: begin
          write_count(dir_tab[k].qx);
        end
        ROW_LOAD: begin
          send_item(OP_LOAD, dir_tab[k].idx, dir_tab[k].sx, dir_tab[k].sy, dir_tab[k].cx,
                    dir_tab[k].cy, dir_tab[k].ex, dir_tab[k].ey, 0, 1'b0, tr);
        end
        default: begin
          send_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, dir_tab[k].qx, dir_tab[k].typed, tr);
        end
      endcase
    end

    // Every slot is written before any count can reach slots beyond the directed ones.
    for (int i = 0; i < SLOTS; i++) load_random(i);
    total = 33;

    for (int p = 0; total < 1650; p++) begin
      write_count(counts[p % 12]);
      n = (seg_cnt > SLOTS) ? SLOTS : seg_cnt;
      phase_len = (n > 8) ? 25 : 130;
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 3) begin
          load_random($urandom_range(0, SLOTS - 1));
        end else begin
          tr = '{default: '0};
          if (n > 0 && $urandom_range(0, 9) < 7) begin
            slot = $urandom_range(0, n - 1);
            lo = int'(tab_sx[slot] < tab_ex[slot] ? tab_sx[slot] : tab_ex[slot]);
            hi = int'(tab_sx[slot] < tab_ex[slot] ? tab_ex[slot] : tab_sx[slot]);
            send_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0,
                      lo + int'($urandom_range(0, hi - lo)), 1'b0, tr);
          end else begin
            send_item(OP_QUERY, $urandom_range(0, 15), rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 1'b0, tr);
          end
        end
        total++;
      end
    end

    drain_block();
    if (pending_heights.size() != 0) errors++;
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bhl_pkg.sv
rtl/core/bhl_ram.sv
rtl/core/bhl_mul.sv
rtl/core/bhl_sqrt.sv
rtl/core/bhl_div.sv
rtl/core/piecewise_bezier_height_lookup.sv
sim/tb_piecewise_bezier_height_lookup.sv
